>>> rtl/multi_timer_deadline_table_macros.svh
// ----------------------------------------------------------------------------
// multi_timer_deadline_table_macros
// Assertion macros for the timer table.
// ----------------------------------------------------------------------------
`ifndef MULTI_TIMER_DEADLINE_TABLE_MACROS_SVH
`define MULTI_TIMER_DEADLINE_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define MTDT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MTDT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTDT_ASSERT(lbl, prop, msg)
`define MTDT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> rtl/mtdt_pkg.sv
// ----------------------------------------------------------------------------
// mtdt_pkg
// Types, codes and helpers shared by the timer table cells and the top level.
// ----------------------------------------------------------------------------
package mtdt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;

  typedef enum logic [2:0] {
    OP_ADD_ONE = 3'd0,
    OP_ADD_PER = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_QUERY   = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NO_TMR  = 3'd2,
    ST_FIRED   = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  // Operation token that walks the row of cells.
  typedef struct packed {
    logic               vld;
    logic [2:0]         op;
    logic [31:0]        now;
    logic [31:0]        dly;
    logic [31:0]        per;
    logic [3:0]         tgt;
    logic signed [32:0] req;
    logic               done;
    logic [3:0]         hit;
    logic [4:0]         nfire;
  } pkt_t;

  // Fire report from a cell.
  typedef struct packed {
    logic       fire;
    logic [3:0] id;
  } fire_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

>>> rtl/mtdt_cell.sv
// ----------------------------------------------------------------------------
// mtdt_cell
// One timer slot. Applies the passing token to its slot and hands it on.
// ----------------------------------------------------------------------------
module mtdt_cell
  import mtdt_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  pkt_t  pkt_in,
  output pkt_t  pkt_out,
  output fire_t fire_o
);

  localparam logic [31:0] IDX_W = 32'(IDX);

  logic        active_r, active_nxt;
  logic        periodic_r, periodic_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [31:0] per_r, per_nxt;
  pkt_t        pkt_r, pkt_nxt;

  logic signed [32:0] rem;
  logic [31:0]        reload;

  // slot update for the token in this cell
  always_comb begin
    active_nxt   = active_r;
    periodic_nxt = periodic_r;
    dl_nxt       = dl_r;
    per_nxt      = per_r;
    pkt_nxt      = pkt_in;
    fire_o       = '0;
    rem          = (dl_r > pkt_in.now) ? $signed({1'b0, dl_r - pkt_in.now}) : 33'sd0;
    reload       = sat_add(dl_r, per_r);
    if (reload <= pkt_in.now) begin
      reload = sat_add(pkt_in.now, per_r);
    end
    if (pkt_in.vld) begin
      case (pkt_in.op)
        OP_ADD_ONE, OP_ADD_PER: begin
          if (!pkt_in.done && !active_r) begin
            active_nxt   = 1'b1;
            periodic_nxt = (pkt_in.op == OP_ADD_PER);
            dl_nxt       = sat_add(pkt_in.now, pkt_in.dly);
            per_nxt      = (pkt_in.op == OP_ADD_PER) ? pkt_in.per : 32'd0;
            pkt_nxt.done = 1'b1;
            pkt_nxt.hit  = IDX_W[3:0];
          end
        end
        OP_REMOVE: begin
          if (({28'd0, pkt_in.tgt} == IDX_W) && active_r) begin
            active_nxt   = 1'b0;
            periodic_nxt = 1'b0;
            pkt_nxt.done = 1'b1;
          end
        end
        OP_QUERY: begin
          if (active_r && (pkt_in.req < 0 || rem < pkt_in.req)) begin
            pkt_nxt.req = rem;
          end
        end
        OP_TICK: begin
          if (active_r && pkt_in.now >= dl_r && pkt_in.nfire < 5'(MAX_RESULTS)) begin
            fire_o.fire   = 1'b1;
            fire_o.id     = IDX_W[3:0];
            pkt_nxt.nfire = pkt_in.nfire + 5'd1;
            if (!periodic_r) begin
              active_nxt = 1'b0;
            end else begin
              dl_nxt = reload;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r   <= 1'b0;
      periodic_r <= 1'b0;
      pkt_r.vld  <= 1'b0;
    end else if (adv) begin
      active_r   <= active_nxt;
      periodic_r <= periodic_nxt;
      pkt_r      <= pkt_nxt;
    end
  end

  // slot payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r  <= dl_nxt;
      per_r <= per_nxt;
    end
  end

  assign pkt_out = pkt_r;

endmodule

>>> rtl/multi_timer_deadline_table.sv
// ----------------------------------------------------------------------------
// multi_timer_deadline_table
// Timer table built as a row of slot cells walked by one operation token.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in_     | input     | valid/stall, operation now_time delay period target_id
//          |           | requested_timeout
//  out_    | output    | valid/stall, status slot_id capped_timeout last
//
// The token moves one cell per cycle while the row is not frozen, and the
// result is formed as it leaves the last cell. A new item is taken after that.
// Output stall freezes the whole row while a fire report or the final result
// cannot be placed. Reset clears all slots at once; no clearing pass.
module multi_timer_deadline_table
  import mtdt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [31:0]        in_now_time,
  input  logic [31:0]        in_delay,
  input  logic [31:0]        in_period,
  input  logic [3:0]         in_target_id,
  input  logic signed [32:0] in_requested_timeout,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [3:0]         out_slot_id,
  output logic signed [32:0] out_capped_timeout,
  output logic               out_last
);

  `include "multi_timer_deadline_table_macros.svh"

  pkt_t  chain [SLOTS+1];
  fire_t fires [SLOTS];
  logic [SLOTS-1:0] fire_vec;

  logic busy_r;
  logic hold_v_r;
  logic [3:0] hold_id_r;
  logic out_valid_r;
  logic [2:0] status_r;
  logic [3:0] slot_r;
  logic signed [32:0] tmo_r;
  logic last_r;

  logic any_fire, out_free, adv, tail_vld, accept;
  logic [3:0] fire_id;
  pkt_t tail;

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;

  // token launch
  always_comb begin
    chain[0]       = '0;
    chain[0].vld   = accept;
    chain[0].op    = in_operation;
    chain[0].now   = in_now_time;
    chain[0].dly   = in_delay;
    chain[0].per   = in_period;
    chain[0].tgt   = in_target_id;
    chain[0].req   = in_requested_timeout;
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    mtdt_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .pkt_in (chain[g]),
      .pkt_out(chain[g+1]),
      .fire_o (fires[g])
    );
    assign fire_vec[g] = fires[g].fire;
  end

  // collect fire report, at most one cell holds the token
  always_comb begin
    fire_id = '0;
    for (int i = 0; i < SLOTS; i++) begin
      fire_id = fire_id | fires[i].id;
    end
  end

  assign any_fire = |fire_vec;
  assign tail     = chain[SLOTS];
  assign tail_vld = tail.vld;
  assign out_free = !out_valid_r || !out_stall;
  assign adv      = !(any_fire && hold_v_r && !out_free) && !(tail_vld && !out_free);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        busy_r <= 1'b1;
      end
      if (adv && any_fire) begin
        hold_v_r <= 1'b1;
      end else if (adv && tail_vld) begin
        hold_v_r <= 1'b0;
        busy_r   <= 1'b0;
      end
      if (adv && any_fire && hold_v_r) begin
        out_valid_r <= 1'b1;
      end else if (adv && tail_vld) begin
        out_valid_r <= (tail.op <= OP_TICK);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (adv && any_fire) begin
      hold_id_r <= fire_id;
    end
    if (adv && any_fire && hold_v_r) begin
      status_r <= ST_FIRED;
      slot_r   <= hold_id_r;
      tmo_r    <= '0;
      last_r   <= 1'b0;
    end else if (adv && tail_vld) begin
      last_r <= 1'b1;
      tmo_r  <= '0;
      case (tail.op)
        OP_ADD_ONE, OP_ADD_PER: begin
          status_r <= tail.done ? ST_OK : ST_FULL;
          slot_r   <= tail.done ? tail.hit : 4'd0;
        end
        OP_REMOVE: begin
          status_r <= tail.done ? ST_OK : ST_NO_TMR;
          slot_r   <= tail.tgt;
        end
        OP_QUERY: begin
          status_r <= ST_OK;
          slot_r   <= 4'd0;
          tmo_r    <= tail.req;
        end
        default: begin
          status_r <= hold_v_r ? ST_FIRED : ST_NONE;
          slot_r   <= hold_v_r ? hold_id_r : 4'd0;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_slot_id        = slot_r;
  assign out_capped_timeout = tmo_r;
  assign out_last           = last_r;

  `MTDT_ASSERT(a_one_fire, $onehot0(fire_vec), "more than one cell fired")
  `MTDT_ASSERT(a_tail_busy, tail_vld |-> busy_r, "token in row while idle")
  `MTDT_ASSERT(a_hold_busy, hold_v_r |-> busy_r, "pending fire while idle")

endmodule
